// ----- hdl/gww_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gww_pkg: shared types and constants of the greedy word wrapper
// Command format between front and back, buffer write port, character codes.
// ----------------------------------------------------------------------------
package gww_pkg;

  // Word length, column and line width all fit six bits (line_width is 6 bits).
  localparam int LEN_W       = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_CUT_MODE   = 1'b1;

  typedef struct packed {
    logic [1:0]       head_nl;
    logic             space;
    logic [LEN_W-1:0] word_cnt;
    logic             lit;
    logic [7:0]       lit_char;
    logic             tail_nl;
    logic             warn;
    logic [LEN_W-1:0] total;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage
`default_nettype wire

// ----- hdl/gww_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gww_front: input classifier and line state
// Accepts text beats, tracks word length and column, writes word bytes to the
// buffer and issues one output command per beat that produces bytes.
// ----------------------------------------------------------------------------
module gww_front
  import gww_pkg::*;
#(
  parameter int MAX_WIDTH = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char,
  input  logic             end_of_text,
  input  logic [LEN_W-1:0] line_width,
  input  logic             cut_mode,
  input  logic             q_full,
  input  logic             word_done,
  output logic             push,
  output cmd_t             cmd,
  output buf_wr_t          buf_wr,
  output logic             word_busy
);

  localparam logic [LEN_W-1:0] MAXW = LEN_W'(MAX_WIDTH);

  logic [LEN_W-1:0] word_len, word_len_next;
  logic [LEN_W-1:0] col, col_next;
  logic             warned, warned_next;
  logic             after_nl, after_nl_next;
  logic             pending, pending_next;

  logic [LEN_W-1:0] w, col1, wl1, col2;
  logic [LEN_W:0]   need;
  logic             accept, blank, nl, para, wrap, place;

  assign in_ready = !q_full && !word_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (line_width == '0) begin
      w = LEN_W'(1);
    end else if (line_width > MAXW) begin
      w = MAXW;
    end else begin
      w = line_width;
    end
  end

  always_comb begin
    cmd           = '0;
    buf_wr        = '0;
    word_len_next = word_len;
    col_next      = col;
    warned_next   = warned;
    after_nl_next = after_nl;
    pending_next  = pending;
    col1          = col;
    wl1           = word_len;
    col2          = col;
    need          = '0;
    nl            = 1'b0;
    para          = 1'b0;
    wrap          = 1'b0;
    place         = 1'b0;
    blank = end_of_text || in_char == CH_SPACE || (in_char >= CH_TAB && in_char <= CH_CR);
    if (blank) begin
      nl   = !end_of_text && in_char == CH_NL;
      para = after_nl && nl;
      if (para) begin
        cmd.head_nl = (col != '0) ? 2'd2 : 2'd1;
        col1        = '0;
        wl1         = '0;
      end
      if (nl) begin
        after_nl_next = 1'b1;
      end
      need = {1'b0, col1} + {1'b0, wl1} + (LEN_W+1)'(1);
      wrap = need > {1'b0, w} && !(col1 == '0 && wl1 == w);
      col2 = col1;
      if (wrap) begin
        cmd.head_nl  = cmd.head_nl + 2'd1;
        col2         = '0;
        pending_next = 1'b0;
      end
      col_next = col2;
      place    = wl1 <= w && wl1 != '0;
      if (place) begin
        cmd.space    = col2 != '0;
        cmd.word_cnt = wl1;
        col_next     = col2 + LEN_W'(cmd.space) + wl1;
        pending_next = 1'b1;
      end
      word_len_next = '0;
      if (end_of_text) begin
        cmd.tail_nl   = pending_next;
        col_next      = '0;
        warned_next   = 1'b0;
        after_nl_next = 1'b0;
        pending_next  = 1'b0;
      end
    end else begin
      if (word_len <= w) begin
        buf_wr.en   = 1'b1;
        buf_wr.addr = word_len;
        buf_wr.data = in_char;
        if (word_len == w) begin
          cmd.warn     = !warned;
          warned_next  = 1'b1;
          cmd.head_nl  = (col != '0) ? 2'd1 : 2'd0;
          col_next     = '0;
          cmd.word_cnt = cut_mode ? w : w + LEN_W'(1);
          pending_next = 1'b0;
        end
      end else if (!cut_mode) begin
        cmd.lit      = 1'b1;
        cmd.lit_char = in_char;
      end
      if (word_len <= MAXW) begin
        word_len_next = word_len + LEN_W'(1);
      end
      after_nl_next = 1'b0;
    end
    cmd.total = LEN_W'(cmd.head_nl) + LEN_W'(cmd.space) + cmd.word_cnt
              + LEN_W'(cmd.lit) + LEN_W'(cmd.tail_nl);
    if (!accept) begin
      buf_wr.en = 1'b0;
    end
  end

  assign push = accept && cmd.total != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_len  <= '0;
      col       <= '0;
      warned    <= 1'b0;
      after_nl  <= 1'b0;
      pending   <= 1'b0;
      word_busy <= 1'b0;
    end else begin
      if (accept) begin
        word_len <= word_len_next;
        col      <= col_next;
        warned   <= warned_next;
        after_nl <= after_nl_next;
        pending  <= pending_next;
      end
      if (push && cmd.word_cnt != '0) begin
        word_busy <= 1'b1;
      end else if (word_done) begin
        word_busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gww_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gww_queue: command queue
// Short FIFO of output commands between the front and the back.
// ----------------------------------------------------------------------------
module gww_queue
  import gww_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output cmd_t cmd_out,
  output logic empty
);

  localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gww_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gww_back: byte emitter
// Holds the word buffer, walks each command byte by byte and drives the output
// channel through a registered stage.
// ----------------------------------------------------------------------------
module gww_back
  import gww_pkg::*;
#(
  parameter int MAX_WIDTH = 56
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  cmd_t       cmd_in,
  output logic       pop,
  input  buf_wr_t    buf_wr,
  output logic       word_done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run,
  output logic       long_word_warning
);

  localparam int MEM_DEPTH = MAX_WIDTH + 1;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] mem_q;

  logic             active;
  logic [1:0]       head, head_next;
  logic             space, space_next;
  logic [LEN_W-1:0] word_cnt;
  logic [LEN_W-1:0] idx, idx_next;
  logic             lit, lit_next;
  logic [7:0]       lit_char;
  logic             tail, tail_next;
  logic             warn;
  logic [LEN_W-1:0] rem;

  logic       issue, is_mem, rd_en, last;
  logic [7:0] ch;

  logic       s1_valid, s1_mem, s1_last, s1_warn;
  logic [7:0] s1_char;

  assign pop       = !active && !empty;
  assign issue     = active && (!s1_valid || out_ready);
  assign last      = rem == LEN_W'(1);
  assign rd_en     = issue && is_mem;
  assign word_done = issue && last && word_cnt != '0;

  always_comb begin
    head_next  = head;
    space_next = space;
    idx_next   = idx;
    lit_next   = lit;
    tail_next  = tail;
    is_mem     = 1'b0;
    ch         = CH_NL;
    if (head != 2'd0) begin
      head_next = head - 2'd1;
    end else if (space) begin
      space_next = 1'b0;
      ch         = CH_SPACE;
    end else if (idx != word_cnt) begin
      is_mem   = 1'b1;
      idx_next = idx + LEN_W'(1);
    end else if (lit) begin
      lit_next = 1'b0;
      ch       = lit_char;
    end else begin
      tail_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr[ADDR_W-1:0]] <= buf_wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (pop) begin
        active   <= 1'b1;
        head     <= cmd_in.head_nl;
        space    <= cmd_in.space;
        word_cnt <= cmd_in.word_cnt;
        idx      <= '0;
        lit      <= cmd_in.lit;
        lit_char <= cmd_in.lit_char;
        tail     <= cmd_in.tail_nl;
        warn     <= cmd_in.warn;
        rem      <= cmd_in.total;
      end else if (issue) begin
        head  <= head_next;
        space <= space_next;
        idx   <= idx_next;
        lit   <= lit_next;
        tail  <= tail_next;
        rem   <= rem - LEN_W'(1);
        if (last) begin
          active <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
        s1_mem   <= is_mem;
        s1_char  <= ch;
        s1_last  <= last;
        s1_warn  <= warn;
      end else if (out_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign out_valid         = s1_valid;
  assign out_char          = s1_mem ? mem_q : s1_char;
  assign last_of_run       = s1_last;
  assign long_word_warning = s1_warn;

endmodule
`default_nettype wire

// ----- hdl/greedy_text_word_wrap.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_text_word_wrap: greedy word wrapper for a byte stream
// Refills words into lines of at most line_width columns.
//
// Input channel (in_valid/in_ready): one text byte per beat, or an end marker
// with end_of_text set. Output channel (out_valid/out_ready): one byte per
// beat; last_of_run marks the final byte caused by one input beat, and
// long_word_warning marks every byte of the run that first overflows a word.
// Config channel (cfg_valid/cfg_ready): index 0 is line_width, index 1 is
// cut_mode; always ready, write only while the wrapper is idle.
// Path: each command goes through the queue and the emitter's registers; the
// bytes leave through the output register. Throughput: the emitter gives one
// byte per cycle while out_ready is high, and pauses between runs to load the
// next command. Input is held off while a word is still being read out of the
// word buffer. A stalled receiver holds the output register; input then stops
// once the two-entry queue fills or a placed word awaits readout.
// Reset: line_width MAX_WIDTH, cut_mode 0, empty line, no word, no warning;
// the word buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module greedy_text_word_wrap
  import gww_pkg::*;
#(
  parameter int MAX_WIDTH = 56
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run,
  output logic       long_word_warning,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);

  logic [LEN_W-1:0] line_width;
  logic             cut_mode;

  logic    q_push, q_full, q_pop, q_empty, word_done, word_busy;
  cmd_t    cmd_front, cmd_back;
  buf_wr_t buf_wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LEN_W'(MAX_WIDTH);
      cut_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width <= cfg_data[LEN_W-1:0];
        REG_CUT_MODE:   cut_mode   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  gww_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .end_of_text(end_of_text),
    .line_width (line_width),
    .cut_mode   (cut_mode),
    .q_full     (q_full),
    .word_done  (word_done),
    .push       (q_push),
    .cmd        (cmd_front),
    .buf_wr     (buf_wr),
    .word_busy  (word_busy)
  );

  gww_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .cmd_in (cmd_front),
    .full   (q_full),
    .pop    (q_pop),
    .cmd_out(cmd_back),
    .empty  (q_empty)
  );

  gww_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .empty            (q_empty),
    .cmd_in           (cmd_back),
    .pop              (q_pop),
    .buf_wr           (buf_wr),
    .word_done        (word_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .last_of_run      (last_of_run),
    .long_word_warning(long_word_warning)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    word_done |-> word_busy)
    else $error("word readout finished with no word outstanding");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    word_done |=> !word_busy)
    else $error("word buffer still marked busy after readout");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    buf_wr.en |-> !word_busy)
    else $error("word buffer written while a word is being read out");

endmodule
`default_nettype wire
